@@ rtl/gsbi_pkg.sv @@
// ----------------------------------------------------------------------------
// gsbi_pkg
// Shared types, widths and register map of the sample-boundary indexer.
// ----------------------------------------------------------------------------
package gsbi_pkg;

	localparam int MAX_RESULTS_PER_DOC = 64;
	localparam int CNT_W = $clog2(MAX_RESULTS_PER_DOC + 1);

	localparam int LEN_W  = 16;
	localparam int WIN_W  = 17;
	localparam int NEED_W = 18;
	localparam int SMP_W  = 40;
	localparam int POS_W  = 32;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	// register map, 8 bytes per register
	localparam logic [ADDR_W-1:0] ADDR_WINDOW  = 5'd0;
	localparam logic [ADDR_W-1:0] ADDR_OVERLAP = 5'd8;
	localparam logic [ADDR_W-1:0] ADDR_LIMIT   = 5'd16;

	localparam logic [WIN_W-1:0]  WINDOW_RST  = 17'd2048;
	localparam logic              OVERLAP_RST = 1'b1;
	localparam logic [SMP_W-1:0]  LIMIT_RST   = 40'd1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOP = 4'b0010,
		S_TAIL = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	// result of one boundary step
	typedef struct packed {
		logic              fits;
		logic [LEN_W-1:0]  new_pos;
		logic [LEN_W-1:0]  tail;
		logic [NEED_W-1:0] need_short;
		logic [NEED_W-1:0] reload;
		logic [SMP_W-1:0]  samples_inc;
		logic              hit_limit;
	} step_t;

	function automatic logic [NEED_W-1:0] window_reload(logic [WIN_W-1:0] win, logic ovl);
		logic [WIN_W-1:0] w;
		w = (win == '0) ? WIN_W'(1) : win;
		return NEED_W'(w) + NEED_W'(ovl);
	endfunction

endpackage

@@ rtl/gsbi_if.sv @@
// ----------------------------------------------------------------------------
// gsbi_doc_if / gsbi_sample_if
// Valid/ready channels for document requests and sample boundary results.
// ----------------------------------------------------------------------------
interface gsbi_doc_if;
	logic        valid;
	logic        ready;
	logic [15:0] doc_tokens;
	logic        last_doc;

	modport source (output valid, output doc_tokens, output last_doc, input ready);
	modport sink   (input valid, input doc_tokens, input last_doc, output ready);
endinterface

interface gsbi_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] doc_position;
	logic [15:0] token_offset;
	logic        run_last;
	logic        finished;

	modport source (output valid, output doc_position, output token_offset,
		output run_last, output finished, input ready);
	modport sink   (input valid, input doc_position, input token_offset,
		input run_last, input finished, output ready);
endinterface

@@ rtl/gsbi_step.sv @@
// ----------------------------------------------------------------------------
// gsbi_step
// Shared boundary unit: one window-fit compare, advance and count per cycle.
// ----------------------------------------------------------------------------
module gsbi_step
	import gsbi_pkg::*;
(
	input  logic [LEN_W-1:0]  len,
	input  logic [LEN_W-1:0]  pos,
	input  logic [NEED_W-1:0] need,
	input  logic              ovl,
	input  logic [WIN_W-1:0]  win,
	input  logic [SMP_W-1:0]  samples,
	input  logic [SMP_W-1:0]  limit,
	output step_t             st
);

	logic [LEN_W-1:0] avail;
	logic [LEN_W:0]   adv;

	always_comb begin
		avail          = len - pos;
		st.fits        = (NEED_W'(avail) >= need);
		// need fits in avail here, so the low bits are enough
		adv            = {1'b0, pos} + {1'b0, need[LEN_W-1:0]} - (LEN_W+1)'(ovl);
		st.new_pos     = adv[LEN_W-1:0];
		st.tail        = (len >= LEN_W'(ovl)) ? (len - LEN_W'(ovl)) : '0;
		st.need_short  = need - NEED_W'(avail);
		st.reload      = window_reload(win, ovl);
		st.samples_inc = samples + SMP_W'(1);
		st.hit_limit   = (st.samples_inc >= limit);
	end

endmodule

@@ rtl/greedy_sample_boundary_index_top.sv @@
// ----------------------------------------------------------------------------
// greedy_sample_boundary_index_top
// Cuts a stream of document lengths into fixed windows and reports each
// window start as (document position, token offset).
//
//   channel  dir  handshake          payload
//   doc      in   valid/ready        doc_tokens, last_doc
//   sample   out  valid/ready        doc_position, token_offset, run_last, finished
//   apb      in   psel/penable/pwrite window_length, overlap_token, sample_limit
//
// a document is accepted in S_IDLE; S_LOOP then uses the shared boundary
// unit once per boundary plus once for the remainder, S_TAIL handles the
// tail and S_FIN closes the document; once done, S_LOOP goes straight to S_FIN
// results wait in a pending slot and the output register; a stalled sample
// port freezes the sequencer, doc.ready is low while a document is in work
// reset clears all control state and loads the register reset values
// ----------------------------------------------------------------------------
module greedy_sample_boundary_index_top
	import gsbi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	gsbi_doc_if.sink          doc,
	gsbi_sample_if.source     sample,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_RESULTS_PER_DOC);

	state_t            state_q;
	logic [WIN_W-1:0]  win_q;
	logic              ovl_q;
	logic [SMP_W-1:0]  limit_q;
	logic [POS_W-1:0]  doc_cnt_q;
	logic [NEED_W-1:0] need_q;
	logic [SMP_W-1:0]  samples_q;
	logic              started_q;
	logic              done_q;
	logic [LEN_W-1:0]  len_q;
	logic              last_q;
	logic [LEN_W-1:0]  pos_q;
	logic [CNT_W-1:0]  n_q;
	logic              pend_valid_q;
	logic [LEN_W-1:0]  pend_off_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  out_off_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_rl_q;
	logic              out_fin_q;

	step_t             st;
	logic              gen;
	logic              gen_store;
	logic [LEN_W-1:0]  gen_off;
	logic              fin;
	logic              push;
	logic              stall;
	logic              can_push;
	logic              doc_acc;
	logic              cfg_wr;

	gsbi_step u_step (
		.len     (len_q),
		.pos     (pos_q),
		.need    (need_q),
		.ovl     (ovl_q),
		.win     (win_q),
		.samples (samples_q),
		.limit   (limit_q),
		.st      (st)
	);

	assign doc.ready           = (state_q == S_IDLE);
	assign doc_acc             = doc.valid && doc.ready;
	assign sample.valid        = out_valid_q;
	assign sample.doc_position = out_pos_q;
	assign sample.token_offset = out_off_q;
	assign sample.run_last     = out_rl_q;
	assign sample.finished     = out_fin_q;
	assign can_push            = !out_valid_q || sample.ready;
	assign pready              = 1'b1;
	assign cfg_wr              = psel && penable && pwrite;

	always_comb begin
		gen     = 1'b0;
		gen_off = st.new_pos;
		fin     = 1'b0;
		unique case (state_q)
			S_LOOP: begin
				gen     = !done_q && st.fits;
				gen_off = st.new_pos;
			end
			S_TAIL: begin
				gen     = last_q && !done_q;
				gen_off = st.tail;
			end
			S_FIN: begin
				fin = 1'b1;
			end
			default: begin
				gen = 1'b0;
			end
		endcase
		gen_store = gen && (n_q < MAX_N);
		// a new result moves the pending one out; closing moves it out flagged
		push      = pend_valid_q && (gen_store || fin);
		stall     = push && !can_push;
	end

	always_comb begin
		unique case (paddr)
			ADDR_WINDOW:  prdata = DATA_W'(win_q);
			ADDR_OVERLAP: prdata = DATA_W'(ovl_q);
			ADDR_LIMIT:   prdata = DATA_W'(limit_q);
			default:      prdata = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push && !stall) begin
			out_valid_q <= 1'b1;
		end else if (sample.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !stall) begin
			out_off_q <= pend_off_q;
			out_pos_q <= doc_cnt_q;
			out_rl_q  <= fin;
			out_fin_q <= fin && done_q;
		end
	end

	always_ff @(posedge clk) begin
		if (doc_acc) begin
			len_q <= doc.doc_tokens;
			last_q <= doc.last_doc;
		end
	end

	// sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			win_q        <= WINDOW_RST;
			ovl_q        <= OVERLAP_RST;
			limit_q      <= LIMIT_RST;
			doc_cnt_q    <= '0;
			need_q       <= window_reload(WINDOW_RST, OVERLAP_RST);
			samples_q    <= '0;
			started_q    <= 1'b0;
			done_q       <= 1'b0;
			pos_q        <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_off_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (doc_acc && !done_q) begin
						pos_q        <= '0;
						n_q          <= started_q ? '0 : CNT_W'(1);
						pend_valid_q <= !started_q;
						state_q      <= S_LOOP;
						if (!started_q) begin
							// first request also reports the stream start
							started_q  <= 1'b1;
							pend_off_q <= '0;
							if (samples_q >= limit_q) begin
								done_q <= 1'b1;
							end
						end
					end
				end
				S_LOOP: begin
					if (!stall) begin
						if (done_q) begin
							state_q <= S_FIN;
						end else if (st.fits) begin
							pos_q     <= st.new_pos;
							need_q    <= st.reload;
							samples_q <= st.samples_inc;
							if (st.hit_limit) begin
								done_q <= 1'b1;
							end
						end else begin
							need_q  <= st.need_short;
							state_q <= S_TAIL;
						end
					end
				end
				S_TAIL: begin
					if (!stall) begin
						if (gen) begin
							samples_q <= st.samples_inc;
							done_q    <= 1'b1;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!stall) begin
						pend_valid_q <= 1'b0;
						doc_cnt_q    <= doc_cnt_q + POS_W'(1);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (gen_store && !stall) begin
				pend_valid_q <= 1'b1;
				pend_off_q   <= gen_off;
				n_q          <= n_q + CNT_W'(1);
			end

			if (cfg_wr) begin
				unique case (paddr)
					ADDR_WINDOW: begin
						win_q <= pwdata[WIN_W-1:0];
						if (!started_q) begin
							need_q <= window_reload(pwdata[WIN_W-1:0], ovl_q);
						end
					end
					ADDR_OVERLAP: begin
						ovl_q <= pwdata[0];
						if (!started_q) begin
							need_q <= window_reload(win_q, pwdata[0]);
						end
					end
					ADDR_LIMIT: begin
						limit_q <= pwdata[SMP_W-1:0];
					end
					default: begin
						limit_q <= limit_q;
					end
				endcase
			end
		end
	end

`ifndef ASSERT_OFF
	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= MAX_N)
		else $error("result count per document over limit");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("done flag dropped without reset");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("pending result left behind after document closed");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_fin_q |-> done_q)
		else $error("finished flag without done");

	a_need_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		need_q != '0)
		else $error("window token count reached zero");
`endif

endmodule
